[src/accel_tilt_and_fall_detect_macros.svh]
// Assertion macros shared by the tilt and fall detector RTL.
// Clock clk_i and active-low reset rst_ni are assumed in the calling scope.
`ifndef ACCEL_TILT_AND_FALL_DETECT_MACROS_SVH
`define ACCEL_TILT_AND_FALL_DETECT_MACROS_SVH

// Generic clocked assertion, disabled while in reset
`define ATF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property that must hold whenever a result is presented
`define ATF_ASSERT_ON_OUT(lbl, prop, msg) \
  `ATF_ASSERT(lbl, out_valid_o |-> (prop), msg)

`endif

[src/atf_pkg.sv]
// Shared constants, types and the arctangent table for the tilt/fall detector.
// No dependencies.
`default_nettype none
package atf_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int CORDIC_USED    = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES
                                                                    : ATAN_TABLE_LEN;

  localparam int SQRT_IN_W   = 60;             // 32-bit sum shifted up by 28
  localparam int SQRT_STAGES = SQRT_IN_W / 2;
  localparam int ROOT_W      = SQRT_IN_W / 2;  // root in Q14
  localparam int CW          = 34;             // CORDIC x/y width
  localparam int ZW          = 24;             // CORDIC angle accumulator width
  localparam int LAT         = 2 + SQRT_STAGES + CORDIC_USED + 1;

  localparam logic [15:0] FALL_LOW_RST  = 16'd1253;
  localparam logic [15:0] FALL_HIGH_RST = 16'd10440;
  localparam logic [15:0] ANGLE_MAX     = 16'd9000;

  typedef enum logic [0:0] {
    CFG_FALL_LOW  = 1'b0,
    CFG_FALL_HIGH = 1'b1
  } cfg_idx_e;

  // atan(2^-i) in centidegrees, Q8
  function automatic logic [ZW-1:0] atan_q8(input int i);
    logic [ZW-1:0] v;
    case (i)
      0:  v = ZW'(1152000);
      1:  v = ZW'(680065);
      2:  v = ZW'(359328);
      3:  v = ZW'(182400);
      4:  v = ZW'(91554);
      5:  v = ZW'(45822);
      6:  v = ZW'(22916);
      7:  v = ZW'(11459);
      8:  v = ZW'(5730);
      9:  v = ZW'(2865);
      10: v = ZW'(1432);
      11: v = ZW'(716);
      12: v = ZW'(358);
      13: v = ZW'(179);
      14: v = ZW'(90);
      15: v = ZW'(45);
      16: v = ZW'(22);
      17: v = ZW'(11);
      18: v = ZW'(6);
      19: v = ZW'(3);
      20: v = ZW'(1);
      21: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/atf_sqrt.sv]
// Pipelined digit-by-digit square root: floor(sqrt(s * 2^28)), one root bit per stage.
// Depends on atf_pkg.
`default_nettype none
module atf_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [31:0]               sum_i,
  output logic      [atf_pkg::ROOT_W-1:0] root_o
);

  logic [atf_pkg::SQRT_IN_W-1:0] rem_q [atf_pkg::SQRT_STAGES];
  logic [atf_pkg::SQRT_IN_W-1:0] res_q [atf_pkg::SQRT_STAGES];

  for (genvar k = 0; k < atf_pkg::SQRT_STAGES; k++) begin : g_stage
    localparam logic [atf_pkg::SQRT_IN_W-1:0] BIT =
      atf_pkg::SQRT_IN_W'(1) << (atf_pkg::SQRT_IN_W - 2 - 2 * k);
    logic [atf_pkg::SQRT_IN_W-1:0] rem_in, res_in, trial, rem_d, res_d;

    if (k == 0) begin : g_first
      assign rem_in = {sum_i, 28'd0};
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        res_q[k] <= res_d;
      end
    end
  end

  assign root_o = res_q[atf_pkg::SQRT_STAGES-1][atf_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

[src/atf_cordic.sv]
// Pipelined vectoring CORDIC: atan2(num, den) in centidegrees, rounded and clamped.
// Depends on atf_pkg.
`default_nettype none
module atf_cordic (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [atf_pkg::ROOT_W-1:0] den_i,
  input  wire logic signed [15:0]         num_i,
  output logic signed [14:0]              angle_o
);

  localparam int N = atf_pkg::CORDIC_USED;

  logic signed [atf_pkg::CW-1:0] x_q [N];
  logic signed [atf_pkg::CW-1:0] y_q [N];
  logic signed [atf_pkg::ZW-1:0] z_q [N];
  logic signed [14:0]            angle_q;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [atf_pkg::CW-1:0] x_in, y_in, dx, dy, x_d, y_d;
    logic signed [atf_pkg::ZW-1:0] z_in, z_d;

    if (i == 0) begin : g_first
      assign x_in = $signed({{(atf_pkg::CW - atf_pkg::ROOT_W){1'b0}}, den_i});
      assign y_in = $signed({{(atf_pkg::CW - 16){num_i[15]}}, num_i}) <<< 14;
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    always_comb begin
      dx = y_in >>> i;
      dy = x_in >>> i;
      if (!y_in[atf_pkg::CW-1]) begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + $signed(atf_pkg::atan_q8(i));
      end else begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - $signed(atf_pkg::atan_q8(i));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  // round |z|/256 half away from zero, clamp to ninety degrees
  logic [atf_pkg::ZW-1:0] zabs;
  logic [atf_pkg::ZW-1:0] zrnd;
  logic [15:0]            mag;
  logic signed [14:0]     angle_d;

  always_comb begin
    zabs = z_q[N-1][atf_pkg::ZW-1] ? atf_pkg::ZW'(-z_q[N-1]) : atf_pkg::ZW'(z_q[N-1]);
    zrnd = (zabs + atf_pkg::ZW'(128)) >> 8;
    mag  = (zrnd > atf_pkg::ZW'(atf_pkg::ANGLE_MAX)) ? atf_pkg::ANGLE_MAX : zrnd[15:0];
    angle_d = z_q[N-1][atf_pkg::ZW-1] ? -$signed(mag[14:0]) : $signed(mag[14:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule
`default_nettype wire

[src/accel_tilt_and_fall_detect.sv]
// Top level of the accelerometer tilt and fall detector.
// Uses atf_pkg, atf_sqrt, atf_cordic and accel_tilt_and_fall_detect_macros.svh.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------------
//   in      | in_valid_i/in_stall_o  | accel_x_i, accel_y_i, accel_z_i
//   out     | out_valid_o/out_stall_i| accel_magnitude_o, pitch/roll_centideg_o,
//           |                        | fall_detected_o
//   cfg     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One request per cycle unless a stalled result holds the pipeline.
// Stages: squares, sums, the 30 root-bit stages of the square root, the CORDIC stages, rounding.
// A stalled result freezes the whole pipeline; otherwise a request enters each cycle.
// Reset clears the valid bits and loads the default fall limits.
`default_nettype none
`include "accel_tilt_and_fall_detect_macros.svh"
module accel_tilt_and_fall_detect (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [15:0]             accel_magnitude_o,
  output logic signed [14:0]      pitch_centideg_o,
  output logic signed [14:0]      roll_centideg_o,
  output logic                    fall_detected_o,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i
);

  localparam int N  = atf_pkg::CORDIC_USED;
  localparam int NS = atf_pkg::SQRT_STAGES;

  logic        en;
  logic [15:0] fall_low_q, fall_high_q;
  logic [atf_pkg::LAT-1:0] vld_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_low_q  <= atf_pkg::FALL_LOW_RST;
      fall_high_q <= atf_pkg::FALL_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (atf_pkg::cfg_idx_e'(cfg_idx_i))
        atf_pkg::CFG_FALL_LOW:  fall_low_q  <= cfg_wdata_i;
        atf_pkg::CFG_FALL_HIGH: fall_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en          = !(vld_q[atf_pkg::LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[atf_pkg::LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[atf_pkg::LAT-2:0], in_valid_i};
    end
  end

  // stage 1: squares
  logic signed [15:0] ax1_q, ay1_q;
  logic [30:0]        sx_q, sy_q, sz_q;
  logic signed [31:0] px, py, pz;

  assign px = accel_x_i * accel_x_i;
  assign py = accel_y_i * accel_y_i;
  assign pz = accel_z_i * accel_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= accel_x_i;
      ay1_q <= accel_y_i;
      sx_q  <= px[30:0];
      sy_q  <= py[30:0];
      sz_q  <= pz[30:0];
    end
  end

  // stage 2: sums
  logic signed [15:0] num_q [2][NS+1];
  logic [31:0]        sall_q, syz_q, sxz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sall_q      <= {1'b0, sx_q} + {1'b0, sy_q} + {1'b0, sz_q};
      syz_q       <= {1'b0, sy_q} + {1'b0, sz_q};
      sxz_q       <= {1'b0, sx_q} + {1'b0, sz_q};
      num_q[0][0] <= ax1_q;
      num_q[1][0] <= ay1_q;
    end
  end

  // numerators ride alongside the square root stages
  for (genvar k = 1; k <= NS; k++) begin : g_num
    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[0][k] <= num_q[0][k-1];
        num_q[1][k] <= num_q[1][k-1];
      end
    end
  end

  logic [atf_pkg::ROOT_W-1:0] root_all, root_yz, root_xz;

  atf_sqrt u_sqrt_mag   (.clk_i, .en_i(en), .sum_i(sall_q), .root_o(root_all));
  atf_sqrt u_sqrt_pitch (.clk_i, .en_i(en), .sum_i(syz_q),  .root_o(root_yz));
  atf_sqrt u_sqrt_roll  (.clk_i, .en_i(en), .sum_i(sxz_q),  .root_o(root_xz));

  atf_cordic u_cordic_pitch (
    .clk_i, .en_i(en), .den_i(root_yz), .num_i(num_q[0][NS]), .angle_o(pitch_centideg_o)
  );
  atf_cordic u_cordic_roll (
    .clk_i, .en_i(en), .den_i(root_xz), .num_i(num_q[1][NS]), .angle_o(roll_centideg_o)
  );

  // magnitude: Q14 root, round on the half bit
  logic [15:0] mag_d;
  logic        fall_d;
  logic [15:0] mag_q  [N+1];
  logic        fall_q [N+1];

  assign mag_d  = root_all[29:14] + 16'(root_all[13]);
  assign fall_d = (mag_d < fall_low_q) || (mag_d > fall_high_q);

  for (genvar k = 0; k <= N; k++) begin : g_mag
    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_q[k]  <= (k == 0) ? mag_d  : mag_q[(k == 0) ? 0 : k-1];
        fall_q[k] <= (k == 0) ? fall_d : fall_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign accel_magnitude_o = mag_q[N];
  assign fall_detected_o   = fall_q[N];

  `ATF_ASSERT(a_stall_back, out_valid_o && out_stall_i |-> in_stall_o,
              "pipeline advanced under a stalled result")
  `ATF_ASSERT_ON_OUT(a_mag_range, accel_magnitude_o <= 16'd56756,
                     "magnitude beyond the largest norm")
  `ATF_ASSERT_ON_OUT(a_pitch_range, pitch_centideg_o <= 15'sd9000 && pitch_centideg_o >= -15'sd9000,
                     "pitch outside ninety degrees")
  `ATF_ASSERT_ON_OUT(a_roll_range, roll_centideg_o <= 15'sd9000 && roll_centideg_o >= -15'sd9000,
                     "roll outside ninety degrees")

endmodule
`default_nettype wire

[tb/accel_tilt_and_fall_detect_checker.sv]
// Scoreboard for the tilt and fall detector: watches the sample, result and
// register-write ports, predicts each result and compares. Depends on atf_pkg.
module accel_tilt_and_fall_detect_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [15:0]        accel_magnitude_i,
  input  logic signed [14:0] pitch_centideg_i,
  input  logic signed [14:0] roll_centideg_i,
  input  logic               fall_detected_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]        mag;
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic               fall;
  } tilt_result_t;

  tilt_result_t expected_q[$];
  logic [15:0]  low_lim, high_lim;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int atan_tab(int i);
    int t[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                  5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};
    return t[i];
  endfunction

  function automatic longint tilt_centideg(longint num, longint unsigned sq_other);
    longint x, y, z, dx, dy, r;
    x = longint'(isqrt(sq_other << 28));
    y = num * 16384;
    z = 0;
    for (int i = 0; i < atf_pkg::CORDIC_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_tab(i));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_tab(i));
      end
    end
    r = (z >= 0) ? (z + 128) / 256 : -((-z + 128) / 256);
    if (r > 9000) r = 9000;
    if (r < -9000) r = -9000;
    return r;
  endfunction

  function automatic tilt_result_t predict_tilt(longint ax, longint ay, longint az);
    tilt_result_t    t;
    longint unsigned sx, sy, sz, sum, m;
    sx  = ax * ax;
    sy  = ay * ay;
    sz  = az * az;
    sum = sx + sy + sz;
    m   = isqrt(sum);
    if (sum - m * m > m) m++;
    t.mag   = m[15:0];
    t.pitch = 15'(tilt_centideg(ax, sy + sz));
    t.roll  = 15'(tilt_centideg(ay, sx + sz));
    t.fall  = (m < low_lim) || (m > high_lim);
    return t;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    tilt_result_t e, got;
    if (!rst_ni) begin
      low_lim      <= atf_pkg::FALL_LOW_RST;
      high_lim     <= atf_pkg::FALL_HIGH_RST;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_tilt(accel_x_i, accel_y_i, accel_z_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{accel_magnitude_i, pitch_centideg_i, roll_centideg_i, fall_detected_i};
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected mag=%0d pitch=%0d roll=%0d fall=%0b",
                     $time, e.mag, e.pitch, e.roll, e.fall);
            $display("%0t:          actual   mag=%0d pitch=%0d roll=%0d fall=%0b",
                     $time, got.mag, got.pitch, got.roll, got.fall);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (atf_pkg::cfg_idx_e'(cfg_idx_i))
          atf_pkg::CFG_FALL_LOW:  low_lim  <= cfg_wdata_i;
          atf_pkg::CFG_FALL_HIGH: high_lim <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end
endmodule

[tb/accel_tilt_and_fall_detect_test.sv]
// Top of the tilt and fall detector testbench: clock, reset, sample and
// register stimulus, verdict. Depends on atf_pkg, the detector and the checker module.
module accel_tilt_and_fall_detect_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic signed [15:0] ax = '0, ay = '0, az = '0;
  logic [15:0] mag;
  logic signed [14:0] pitch, roll;
  logic fall;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = atf_pkg::CFG_FALL_LOW;
  logic [15:0] cfg_wdata = '0;
  int fail_count, pending, idle_cycles;
  int stall_mode = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  accel_tilt_and_fall_detect i_dut (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .accel_x_i(ax), .accel_y_i(ay), .accel_z_i(az),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .accel_magnitude_o(mag), .pitch_centideg_o(pitch), .roll_centideg_o(roll),
    .fall_detected_o(fall), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  accel_tilt_and_fall_detect_checker i_check (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_i(in_stall),
    .accel_x_i(ax), .accel_y_i(ay), .accel_z_i(az),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .accel_magnitude_i(mag), .pitch_centideg_i(pitch), .roll_centideg_i(roll),
    .fall_detected_i(fall), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern: off, random, or periodic bursts
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= (($time / 12) % 17) < 6;
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("accel_tilt_and_fall_detect_test: errors");
      $finish;
    end
  end

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      3: return 16'($signed($urandom_range(0, 16000)) - 8000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    ax       <= x;
    ay       <= y;
    az       <= z;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic write_limit(atf_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (atf_pkg::LAT + 4) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    int burst;
    int gap;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && count > 0; k++, count--)
        send_sample(rand_axis(), rand_axis(), rand_axis());
      gap = $urandom_range(0, 6);
      if (gap != 0 && count > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    static logic [15:0] lows[4]  = '{16'd1253, 16'd0, 16'hffff, 16'd4000};
    static logic [15:0] highs[4] = '{16'd10440, 16'hffff, 16'd0, 16'd6000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero vector, axis extremes, zero denominators, mixed signs
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'sh7fff, 16'd0, 16'd0);
    send_sample(16'sh8000, 16'd0, 16'd0);
    send_sample(16'd0, 16'sh7fff, 16'd0);
    send_sample(16'd0, 16'sh8000, 16'd0);
    send_sample(16'd0, 16'd0, 16'sh7fff);
    send_sample(16'd0, 16'd0, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'd0, 16'd0, 16'd4096);
    send_sample(16'd4096, 16'd0, 16'd0);
    send_sample(16'd1, 16'hffff, 16'd0);
    send_sample(16'd1253, 16'd0, 16'd0);
    send_sample(16'd1252, 16'd0, 16'd0);
    send_sample(16'd10440, 16'd0, 16'd0);
    send_sample(16'd10441, 16'd0, 16'd0);
    send_sample(16'hffff, 16'hffff, 16'hffff);
    in_valid <= 1'b0;
    drain();
    for (int p = 0; p < 4; p++) begin
      write_limit(atf_pkg::CFG_FALL_LOW, lows[p]);
      write_limit(atf_pkg::CFG_FALL_HIGH, highs[p]);
      stall_mode = p % 3;
      random_phase(300);
      drain();
    end
    if (fail_count == 0) $display("accel_tilt_and_fall_detect_test: clean");
    else $display("accel_tilt_and_fall_detect_test: errors");
    $finish;
  end
endmodule

[accel_tilt_and_fall_detect.f]
+incdir+src
src/atf_pkg.sv
src/atf_sqrt.sv
src/atf_cordic.sv
src/accel_tilt_and_fall_detect.sv
tb/accel_tilt_and_fall_detect_checker.sv
tb/accel_tilt_and_fall_detect_test.sv
